### sv/assert_macros.svh
// Assertion macros shared by the traffic table RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSTT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PSTT_NEVER(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define PSTT_ASSERT(name, clk, rst, prop, msg)
`define PSTT_NEVER(name, clk, rst, prop, msg)
`endif
`endif

### sv/pstt_pkg.sv
// Types and constants of the per-source traffic table.
// Used by pstt_alu and the top level; depends on nothing.
`default_nettype none
package pstt_pkg;

   localparam int unsigned DEF_TABLE_ENTRIES = 1024;
   localparam int unsigned DEF_PROTOCOLS     = 10;
   localparam int unsigned CNT_W             = 48;
   localparam logic [CNT_W-1:0] CNT_MAX      = '1;

   typedef struct packed {
      logic [31:0] source_address;
      logic [7:0]  protocol_code;
      logic [15:0] packet_length;
   } req_type;

   typedef struct packed {
      logic [9:0]       entry_index;
      logic             entry_created;
      logic             table_full;
      logic [CNT_W-1:0] entry_packets;
      logic [CNT_W-1:0] entry_bytes;
      logic [3:0]       protocol_count;
      logic             protocol_added;
      logic             protocol_set_full;
      logic [CNT_W-1:0] all_packets;
      logic [10:0]      entries_used;
   } rsp_type;

   // Results of the shared arithmetic unit
   typedef struct packed {
      logic [CNT_W-1:0] sum;
      logic             equal;
   } alu_res_type;

endpackage
`default_nettype wire

### sv/pstt_ram.sv
// Simple dual-port memory: one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
`default_nettype none
module pstt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and read the array; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### sv/pstt_alu.sv
// Shared arithmetic unit: 48-bit saturating add and 32-bit equality compare.
// Depends on pstt_pkg.
`default_nettype none
module pstt_alu (
   input  wire logic [pstt_pkg::CNT_W-1:0] add_a,
   input  wire logic [pstt_pkg::CNT_W-1:0] add_b,
   input  wire logic [31:0]                cmp_a,
   input  wire logic [31:0]                cmp_b,
   output pstt_pkg::alu_res_type           res
);
   import pstt_pkg::*;

   logic [CNT_W:0] raw_sum;

   // Add with carry out; both operands fit 48 bits, so carry means overflow
   assign raw_sum   = {1'b0, add_a} + {1'b0, add_b};
   assign res.sum   = raw_sum[CNT_W] ? CNT_MAX : raw_sum[CNT_W-1:0];
   assign res.equal = (cmp_a == cmp_b);

endmodule
`default_nettype wire

### sv/per_source_traffic_table.sv
// Channel    Ports                   Handshake
// request    start, busy, req_item   taken when start is high and busy is low
// response   rsp_strobe, rsp_item    valid for one cycle, cannot be stalled
//
// One transaction scans the address store one slot per cycle until a match or
// the last occupied slot, then, unless the table is full, the entry's protocol
// set one code per cycle, with a single shared adder/comparator doing the
// count sums and compares. busy stays high until the cycle the response
// strobes, when the next request may already be taken.
// Reset is synchronous and clears the table (fill count) and the total.
// Top level of the per-source traffic table; depends on pstt_pkg, pstt_ram,
// pstt_alu and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module per_source_traffic_table #(
   parameter int unsigned TABLE_ENTRIES       = pstt_pkg::DEF_TABLE_ENTRIES,
   parameter int unsigned PROTOCOLS_PER_ENTRY = pstt_pkg::DEF_PROTOCOLS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire pstt_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output pstt_pkg::rsp_type      rsp_item
);
   import pstt_pkg::*;

   localparam int unsigned IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int unsigned OCC_W     = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned PC_W      = $clog2(PROTOCOLS_PER_ENTRY + 1);
   localparam int unsigned SET_DEPTH = TABLE_ENTRIES * PROTOCOLS_PER_ENTRY;
   localparam int unsigned SET_AW    = $clog2(SET_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_TOTAL, ST_PKT, ST_BYTE, ST_PSCAN
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [OCC_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              created_ff, created_in;
   logic              full_ff, full_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [OCC_W-1:0]  occupied_ff, occupied_in;
   logic [SET_AW-1:0] set_base_ff, set_base_in;
   logic [CNT_W-1:0]  pkt_ff, pkt_in;
   logic [CNT_W-1:0]  byte_ff, byte_in;
   logic [PC_W-1:0]   pn_ff, pn_in;
   logic [PC_W-1:0]   pidx_ff, pidx_in;
   logic              pcmp_v_ff, pcmp_v_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // Memory ports
   logic              addr_wr_en, addr_rd_en;
   logic [IDX_W-1:0]  addr_rd_addr;
   logic [31:0]       addr_rd_data;
   logic              ent_wr_pkt, ent_wr_byte, ent_wr_pcnt, ent_rd_en;
   logic [CNT_W-1:0]  pkt_rd_data, byte_rd_data;
   logic [PC_W-1:0]   pcnt_wr_data, pcnt_rd_data;
   logic              set_wr_en, set_rd_en;
   logic [SET_AW-1:0] set_wr_addr, set_rd_addr;
   logic [7:0]        set_rd_data;

   // Shared unit operands
   logic [CNT_W-1:0]  add_a, add_b;
   logic [31:0]       cmp_a, cmp_b;
   alu_res_type       alu_res;

   pstt_alu u_alu (
      .add_a (add_a),
      .add_b (add_b),
      .cmp_a (cmp_a),
      .cmp_b (cmp_b),
      .res   (alu_res)
   );

   pstt_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (slot_in),
      .wr_data (req_ff.source_address),
      .rd_en   (addr_rd_en),
      .rd_addr (addr_rd_addr),
      .rd_data (addr_rd_data)
   );

   pstt_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_pkt_ram (
      .clock   (clock),
      .wr_en   (ent_wr_pkt),
      .wr_addr (slot_ff),
      .wr_data (pkt_in),
      .rd_en   (ent_rd_en),
      .rd_addr (slot_ff),
      .rd_data (pkt_rd_data)
   );

   pstt_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_ENTRIES)) u_byte_ram (
      .clock   (clock),
      .wr_en   (ent_wr_byte),
      .wr_addr (slot_ff),
      .wr_data (byte_in),
      .rd_en   (ent_rd_en),
      .rd_addr (slot_ff),
      .rd_data (byte_rd_data)
   );

   pstt_ram #(.WIDTH(PC_W), .DEPTH(TABLE_ENTRIES)) u_pcnt_ram (
      .clock   (clock),
      .wr_en   (ent_wr_pcnt),
      .wr_addr (slot_ff),
      .wr_data (pcnt_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (slot_ff),
      .rd_data (pcnt_rd_data)
   );

   pstt_ram #(.WIDTH(8), .DEPTH(SET_DEPTH)) u_set_ram (
      .clock   (clock),
      .wr_en   (set_wr_en),
      .wr_addr (set_wr_addr),
      .wr_data (req_ff.protocol_code),
      .rd_en   (set_rd_en),
      .rd_addr (set_rd_addr),
      .rd_data (set_rd_data)
   );

   // Sequence one transaction through scan, update and protocol search
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      scan_cnt_in   = scan_cnt_ff;
      cmp_v_in      = cmp_v_ff;
      cmp_idx_in    = cmp_idx_ff;
      slot_in       = slot_ff;
      created_in    = created_ff;
      full_in       = full_ff;
      total_in      = total_ff;
      occupied_in   = occupied_ff;
      set_base_in   = set_base_ff;
      pkt_in        = pkt_ff;
      byte_in       = byte_ff;
      pn_in         = pn_ff;
      pidx_in       = pidx_ff;
      pcmp_v_in     = pcmp_v_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      addr_wr_en    = 1'b0;
      addr_rd_en    = 1'b0;
      addr_rd_addr  = scan_cnt_ff[IDX_W-1:0];
      ent_wr_pkt    = 1'b0;
      ent_wr_byte   = 1'b0;
      ent_wr_pcnt   = 1'b0;
      ent_rd_en     = 1'b0;
      pcnt_wr_data  = pn_ff + PC_W'(1);
      set_wr_en     = 1'b0;
      set_wr_addr   = set_base_ff + SET_AW'(pn_ff);
      set_rd_en     = 1'b0;
      set_rd_addr   = set_base_ff + SET_AW'(pidx_ff);

      add_a = total_ff;
      add_b = CNT_W'(1);
      cmp_a = req_ff.source_address;
      cmp_b = addr_rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in      = req_item;
               scan_cnt_in = '0;
               cmp_v_in    = 1'b0;
               created_in  = 1'b0;
               full_in     = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Compare the slot read last cycle, issue the next read
            if (cmp_v_ff && alu_res.equal) begin
               slot_in  = cmp_idx_ff;
               state_in = ST_TOTAL;
            end else if (scan_cnt_ff < occupied_ff) begin
               addr_rd_en  = 1'b1;
               cmp_idx_in  = scan_cnt_ff[IDX_W-1:0];
               cmp_v_in    = 1'b1;
               scan_cnt_in = scan_cnt_ff + OCC_W'(1);
            end else begin
               if (occupied_ff == OCC_W'(TABLE_ENTRIES)) begin
                  full_in = 1'b1;
               end else begin
                  slot_in     = occupied_ff[IDX_W-1:0];
                  created_in  = 1'b1;
                  addr_wr_en  = 1'b1;
                  occupied_in = occupied_ff + OCC_W'(1);
               end
               state_in = ST_TOTAL;
            end
         end
         ST_TOTAL: begin
            // Count the packet; if the table is full respond, else fetch the entry and locate its protocol set
            total_in    = alu_res.sum;
            ent_rd_en   = !full_ff;
            set_base_in = SET_AW'(slot_ff) * SET_AW'(PROTOCOLS_PER_ENTRY);
            if (full_ff) begin
               rsp_in               = '0;
               rsp_in.table_full    = 1'b1;
               rsp_in.all_packets   = alu_res.sum;
               rsp_in.entries_used  = 11'(occupied_ff);
               rsp_strobe_in        = 1'b1;
               state_in             = ST_IDLE;
            end else begin
               state_in = ST_PKT;
            end
         end
         ST_PKT: begin
            add_a      = created_ff ? '0 : pkt_rd_data;
            add_b      = CNT_W'(1);
            pkt_in     = alu_res.sum;
            ent_wr_pkt = 1'b1;
            state_in   = ST_BYTE;
         end
         ST_BYTE: begin
            add_a       = created_ff ? '0 : byte_rd_data;
            add_b       = CNT_W'(req_ff.packet_length);
            byte_in     = alu_res.sum;
            ent_wr_byte = 1'b1;
            pn_in       = created_ff ? '0 : pcnt_rd_data;
            pidx_in     = '0;
            pcmp_v_in   = 1'b0;
            state_in    = ST_PSCAN;
         end
         ST_PSCAN: begin
            cmp_a = 32'(req_ff.protocol_code);
            cmp_b = 32'(set_rd_data);
            rsp_in.entry_index       = 10'(slot_ff);
            rsp_in.entry_created     = created_ff;
            rsp_in.table_full        = 1'b0;
            rsp_in.entry_packets     = pkt_ff;
            rsp_in.entry_bytes       = byte_ff;
            rsp_in.protocol_count    = 4'(pn_ff);
            rsp_in.protocol_added    = 1'b0;
            rsp_in.protocol_set_full = 1'b0;
            rsp_in.all_packets       = total_ff;
            rsp_in.entries_used      = 11'(occupied_ff);
            if (pcmp_v_ff && alu_res.equal) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else if (pidx_ff < pn_ff) begin
               set_rd_en = 1'b1;
               pidx_in   = pidx_ff + PC_W'(1);
               pcmp_v_in = 1'b1;
            end else begin
               // Protocol unseen: append it, or flag the full set
               if (pn_ff == PC_W'(PROTOCOLS_PER_ENTRY)) begin
                  rsp_in.protocol_set_full = 1'b1;
               end else begin
                  set_wr_en             = 1'b1;
                  ent_wr_pcnt           = 1'b1;
                  rsp_in.protocol_added = 1'b1;
                  rsp_in.protocol_count = 4'(pn_ff + PC_W'(1));
               end
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, counters and the registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occupied_ff   <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         cmp_v_ff      <= 1'b0;
         pcmp_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occupied_ff   <= occupied_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cmp_v_ff      <= cmp_v_in;
         pcmp_v_ff     <= pcmp_v_in;
      end
      req_ff      <= req_in;
      scan_cnt_ff <= scan_cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_ff     <= slot_in;
      created_ff  <= created_in;
      full_ff     <= full_in;
      set_base_ff <= set_base_in;
      pkt_ff      <= pkt_in;
      byte_ff     <= byte_in;
      pn_ff       <= pn_in;
      pidx_ff     <= pidx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `PSTT_ASSERT(a_take_sets_busy, clock, reset, (start && !busy) |=> busy, "busy not raised")
   `PSTT_ASSERT(a_rsp_after_work, clock, reset, rsp_strobe |-> $past(busy), "stray response")
   `PSTT_ASSERT(a_occ_bound, clock, reset, occupied_ff <= OCC_W'(TABLE_ENTRIES), "overfill")
   `PSTT_ASSERT(a_full_only_when_full, clock, reset, (rsp_strobe && rsp_item.table_full) |-> (occupied_ff == OCC_W'(TABLE_ENTRIES)), "table_full early")
   `PSTT_NEVER(a_created_and_full, clock, reset, rsp_strobe && rsp_item.entry_created && rsp_item.table_full, "created and full")
   `PSTT_ASSERT(a_set_bound, clock, reset, (state_ff == ST_PSCAN) |-> (pn_ff <= PC_W'(PROTOCOLS_PER_ENTRY)), "protocol count overrun")

endmodule
`default_nettype wire
